/* rtl/stack_machine_executor_defines.svh */
// Assertion macros shared by the stack machine executor RTL.
`ifndef STACK_MACHINE_EXECUTOR_DEFINES_SVH
`define STACK_MACHINE_EXECUTOR_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define SME_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define SME_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SME_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define SME_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

/* rtl/sme_pkg.sv */
// Shared widths, defaults and opcode constants for the stack machine executor.
package sme_pkg;

  localparam int OP_W            = 8;
  localparam int WORD_W          = 32;
  localparam int CHAR_W          = 8;
  localparam int DEPTH_W         = 5;
  localparam int STACK_DEPTH_DEF = 16;

  localparam logic [OP_W-1:0] OPC_NOP   = 8'h00;
  localparam logic [OP_W-1:0] OPC_PUSH  = 8'h01;
  localparam logic [OP_W-1:0] OPC_POP   = 8'h02;
  localparam logic [OP_W-1:0] OPC_ADD   = 8'h03;
  localparam logic [OP_W-1:0] OPC_SUB   = 8'h04;
  localparam logic [OP_W-1:0] OPC_MUL   = 8'h05;
  localparam logic [OP_W-1:0] OPC_XOR   = 8'h07;
  localparam logic [OP_W-1:0] OPC_PRINT = 8'h0F;
  localparam logic [OP_W-1:0] OPC_HALT  = 8'h11;

endpackage

/* rtl/sme_channels.sv */
// Valid/ready channel interfaces for instruction items and result items.
interface sme_in_if import sme_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [WORD_W-1:0] operand;

  modport source (output valid, output op, output operand, input ready);
  modport sink   (input valid, input op, input operand, output ready);
endinterface

interface sme_out_if import sme_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               char_valid;
  logic [CHAR_W-1:0]  char_code;
  logic               halted;
  logic [DEPTH_W-1:0] depth;

  modport source (output valid, output char_valid, output char_code, output halted,
                  output depth, input ready);
  modport sink   (input valid, input char_valid, input char_code, input halted,
                  input depth, output ready);
endinterface

/* rtl/sme_ram.sv */
// Generic single-port RAM with registered read data.
module sme_ram import sme_pkg::*; #(
  parameter int WIDTH = WORD_W,
  parameter int DEPTH = STACK_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* rtl/sme_alu.sv */
// Wrapping 32-bit binary operations: add, sub, low-half multiply and xor.
module sme_alu import sme_pkg::*; (
  input  logic [OP_W-1:0]   op,
  input  logic [WORD_W-1:0] a,
  input  logic [WORD_W-1:0] b,
  output logic [WORD_W-1:0] y
);

  always_comb begin
    case (op)
      OPC_ADD: y = a + b;
      OPC_SUB: y = a - b;
      OPC_MUL: y = a * b;
      default: y = a ^ b;
    endcase
  end

endmodule

/* rtl/stack_machine_executor.sv */
// Top level of the stack machine executor: control, top-of-stack cache and result register.
`include "stack_machine_executor_defines.svh"

// Each accepted item is one instruction (opcode and 32-bit immediate) applied to a bounded
// stack of STACK_DEPTH 32-bit words; each item yields exactly one result item carrying the
// printed character (if any), the sticky halt flag and the stack depth after the instruction.
// The top word is held in a register and the words below it live in a single-port memory
// with registered read data. Push, nop, halt, unknown opcodes, ignored items and a pop or
// print that empties the stack need no memory read, so such items can be accepted back to
// back. Pop, print and the binary operations on a stack of two or more words need a refill:
// the word below the top is read from the memory at acceptance and lands in the top register
// (through the ALU for binary operations) in a refill state during which no new item is
// accepted. The result is registered at acceptance, so a waiting result does not stop the
// next item as long as the consumer takes it in the same cycle. Once halt has executed,
// every further item is accepted and answered with the unchanged depth until reset.
module stack_machine_executor import sme_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input logic      clk,
  input logic      rst_n,
  sme_in_if.sink   in_if,
  sme_out_if.source out_if
);

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int AW    = $clog2(STACK_DEPTH);

  // Control state.
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             halt_r, halt_nxt;
  logic             busy_r, busy_nxt;
  logic             pend_bin_r, pend_bin_nxt;
  logic [OP_W-1:0]  pend_op_r, pend_op_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Payload state.
  logic [WORD_W-1:0]  top_r, top_nxt;
  logic               char_valid_r, char_valid_nxt;
  logic [CHAR_W-1:0]  char_code_r, char_code_nxt;
  logic               halted_r, halted_nxt;
  logic [DEPTH_W-1:0] depth_r, depth_nxt;

  // Decode of the item at the input.
  logic acc;
  logic is_bin;
  logic do_push, do_pop, do_print, do_bin, do_halt;
  logic need_read;
  logic has_one, has_two, not_full;

  // Memory and ALU connections.
  logic              ram_we;
  logic [AW-1:0]     ram_addr;
  logic [WORD_W-1:0] ram_rdata;
  logic [WORD_W-1:0] alu_y;

  assign in_if.ready = !busy_r && (!out_valid_r || out_if.ready);
  assign acc         = in_if.valid && in_if.ready;

  assign has_one  = (count_r != '0);
  assign has_two  = (count_r >= CNT_W'(2));
  assign not_full = (count_r < CNT_W'(STACK_DEPTH));
  assign is_bin   = (in_if.op == OPC_ADD) || (in_if.op == OPC_SUB) ||
                    (in_if.op == OPC_MUL) || (in_if.op == OPC_XOR);

  assign do_push  = !halt_r && (in_if.op == OPC_PUSH) && not_full;
  assign do_pop   = !halt_r && (in_if.op == OPC_POP) && has_one;
  assign do_print = !halt_r && (in_if.op == OPC_PRINT) && has_one;
  assign do_bin   = !halt_r && is_bin && has_two;
  assign do_halt  = !halt_r && (in_if.op == OPC_HALT);

  // The word below the top must be fetched whenever the top is consumed and another remains.
  assign need_read = do_bin || ((do_pop || do_print) && has_two);

  // A push spills the current top into the memory; otherwise the address reads the word
  // below the top.
  assign ram_we   = acc && do_push && has_one;
  assign ram_addr = ram_we ? AW'(count_r - CNT_W'(1)) : AW'(count_r - CNT_W'(2));

  sme_ram #(
    .WIDTH (WORD_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (top_r),
    .rdata (ram_rdata)
  );

  // Second from top is the left operand, the cached top the right one.
  sme_alu u_alu (
    .op (pend_op_r),
    .a  (ram_rdata),
    .b  (top_r),
    .y  (alu_y)
  );

  always_comb begin
    count_nxt    = count_r;
    halt_nxt     = halt_r;
    busy_nxt     = 1'b0;
    pend_bin_nxt = pend_bin_r;
    pend_op_nxt  = pend_op_r;
    top_nxt      = top_r;

    if (busy_r) begin
      top_nxt = pend_bin_r ? alu_y : ram_rdata;
    end

    if (acc) begin
      busy_nxt     = need_read;
      pend_bin_nxt = do_bin;
      pend_op_nxt  = in_if.op;
      if (do_push) begin
        count_nxt = count_r + CNT_W'(1);
        top_nxt   = in_if.operand;
      end
      if (do_pop || do_print || do_bin) begin
        count_nxt = count_r - CNT_W'(1);
      end
      if (do_halt) begin
        halt_nxt = 1'b1;
      end
    end
  end

  // The result is complete at acceptance: it needs only the cached top and the new count.
  always_comb begin
    out_valid_nxt  = out_valid_r && !out_if.ready;
    char_valid_nxt = char_valid_r;
    char_code_nxt  = char_code_r;
    halted_nxt     = halted_r;
    depth_nxt      = depth_r;
    if (acc) begin
      out_valid_nxt  = 1'b1;
      char_valid_nxt = do_print;
      char_code_nxt  = do_print ? top_r[CHAR_W-1:0] : '0;
      halted_nxt     = halt_r || do_halt;
      depth_nxt      = DEPTH_W'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      halt_r      <= 1'b0;
      busy_r      <= 1'b0;
      pend_bin_r  <= 1'b0;
      pend_op_r   <= OPC_NOP;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      halt_r      <= halt_nxt;
      busy_r      <= busy_nxt;
      pend_bin_r  <= pend_bin_nxt;
      pend_op_r   <= pend_op_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_r        <= top_nxt;
    char_valid_r <= char_valid_nxt;
    char_code_r  <= char_code_nxt;
    halted_r     <= halted_nxt;
    depth_r      <= depth_nxt;
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.char_valid = char_valid_r;
  assign out_if.char_code  = char_code_r;
  assign out_if.halted     = halted_r;
  assign out_if.depth      = depth_r;

  // The stack never holds more words than it has room for.
  `SME_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_r <= CNT_W'(STACK_DEPTH), "stack count over depth")
  // A refill blocks the input meanwhile, and the busy flag clears right after it.
  `SME_ASSERT_NOW(a_busy_blocks, clk, rst_n, busy_r, !in_if.ready, "item accepted during refill")
  `SME_ASSERT_NEXT(a_busy_once, clk, rst_n, busy_r, !busy_r, "refill lasted more than one cycle")
  // Once halted, the machine stays halted and the count stays put.
  `SME_ASSERT_NEXT(a_halt_sticky, clk, rst_n, halt_r, halt_r && $stable(count_r), "state changed after halt")

endmodule

/* bench/tb.sv */
// Self-checking testbench for the stack machine executor.
module tb;
  import sme_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Opcodes that the block treats as no operation, used to probe the decoder.
  localparam logic [OP_W-1:0] OPC_UNUSED_GAP = 8'h06;
  localparam logic [OP_W-1:0] OPC_ALL_ONES   = 8'hFF;

  // Cycles without any handshake before the run is declared hung.
  localparam int QUIET_LIMIT  = 5000;
  localparam int RANDOM_ITEMS = 210;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [WORD_W-1:0] operand;
  } instr_t;

  typedef struct packed {
    logic               char_valid;
    logic [CHAR_W-1:0]  char_code;
    logic               halted;
    logic [DEPTH_W-1:0] depth;
  } status_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  sme_in_if  in_ch ();
  sme_out_if out_ch ();

  stack_machine_executor dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  always #10 clk = ~clk;

  // Instructions waiting to be offered, and the status items the block still owes.
  instr_t  pending_instrs[$];
  status_t owed_status[$];

  // Idling controls, changed by the stimulus process between phases.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // Shadow of the machine state, advanced once per accepted instruction.
  logic [WORD_W-1:0] stack_shadow[STACK_DEPTH_DEF];
  int                stack_used;
  logic              halt_seen;

  // Run statistics.
  int fail_count = 0;
  int executed = 0;
  int chars_printed = 0;
  int pushes_dropped = 0;
  int peak_depth = 0;
  int quiet_cycles = 0;

  // Depth estimate that the stimulus uses to build sensible programs.
  int plan_depth = 0;

  // Applies one instruction to the shadow state and returns the status it must produce.
  function automatic status_t execute_instruction(input logic [OP_W-1:0] opc,
                                                  input logic [WORD_W-1:0] imm);
    status_t           res;
    logic [WORD_W-1:0] top;
    logic [WORD_W-1:0] below;
    res = '0;
    if (!halt_seen) begin
      case (opc)
        OPC_PUSH: begin
          if (stack_used < STACK_DEPTH_DEF) begin
            stack_shadow[stack_used] = imm;
            stack_used++;
          end else begin
            pushes_dropped++;
          end
        end
        OPC_POP: begin
          if (stack_used > 0) stack_used--;
        end
        OPC_ADD, OPC_SUB, OPC_MUL, OPC_XOR: begin
          if (stack_used >= 2) begin
            top = stack_shadow[stack_used-1];
            below = stack_shadow[stack_used-2];
            // The word below the top is the left operand.
            case (opc)
              OPC_ADD: stack_shadow[stack_used-2] = below + top;
              OPC_SUB: stack_shadow[stack_used-2] = below - top;
              OPC_MUL: stack_shadow[stack_used-2] = below * top;
              default: stack_shadow[stack_used-2] = below ^ top;
            endcase
            stack_used--;
          end
        end
        OPC_PRINT: begin
          if (stack_used > 0) begin
            res.char_valid = 1'b1;
            res.char_code = stack_shadow[stack_used-1][CHAR_W-1:0];
            stack_used--;
          end
        end
        OPC_HALT: halt_seen = 1'b1;
        default: ;
      endcase
    end
    res.halted = halt_seen;
    res.depth = stack_used[DEPTH_W-1:0];
    return res;
  endfunction

  // Driver: offers the oldest pending instruction and holds it until it is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) void'(pending_instrs.pop_front());
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_instrs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_ch.valid <= 1'b1;
          in_ch.op <= pending_instrs[0].op;
          in_ch.operand <= pending_instrs[0].operand;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result consumer: ready is dropped at random to stall the block.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Monitor: checks each status item against the oldest prediction, then predicts
  // the status for an instruction taken at this edge. Both happen in one process,
  // so the order of the two checks never depends on the simulator.
  always @(posedge clk) begin
    if (!rst_n) begin
      stack_used <= 0;
      halt_seen <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (owed_status.size() == 0) begin
          $error("status item with no instruction outstanding");
          fail_count++;
        end else begin
          if (out_ch.char_valid !== owed_status[0].char_valid) begin
            $error("char_valid: expected %0d, got %0d",
                   owed_status[0].char_valid, out_ch.char_valid);
            fail_count++;
          end
          if (out_ch.char_code !== owed_status[0].char_code) begin
            $error("char_code: expected 0x%02h, got 0x%02h",
                   owed_status[0].char_code, out_ch.char_code);
            fail_count++;
          end
          if (out_ch.halted !== owed_status[0].halted) begin
            $error("halted: expected %0d, got %0d", owed_status[0].halted, out_ch.halted);
            fail_count++;
          end
          if (out_ch.depth !== owed_status[0].depth) begin
            $error("depth: expected %0d, got %0d", owed_status[0].depth, out_ch.depth);
            fail_count++;
          end
          if (owed_status[0].char_valid) chars_printed++;
          void'(owed_status.pop_front());
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        owed_status.push_back(execute_instruction(in_ch.op, in_ch.operand));
        executed++;
        if (stack_used > peak_depth) peak_depth = stack_used;
      end
    end
  end

  // Watchdog: a long stretch with no handshake on either side means a hang.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Timeout: no handshake for %0d cycles", QUIET_LIMIT);
        $display("** stack_machine_executor: FAILED **");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Queues one instruction and tracks the stack depth it should leave behind.
  task automatic add_instr(input logic [OP_W-1:0] opc, input logic [WORD_W-1:0] imm);
    instr_t it;
    it.op = opc;
    it.operand = imm;
    pending_instrs.push_back(it);
    case (opc)
      OPC_PUSH: if (plan_depth < STACK_DEPTH_DEF) plan_depth++;
      OPC_POP, OPC_PRINT: if (plan_depth > 0) plan_depth--;
      OPC_ADD, OPC_SUB, OPC_MUL, OPC_XOR: if (plan_depth >= 2) plan_depth--;
      default: ;
    endcase
  endtask

  // Operands favor the corners of the 32-bit range and printable characters.
  function automatic logic [WORD_W-1:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      4: return $urandom_range(32, 126);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [OP_W-1:0] pick_binop();
    case ($urandom_range(0, 3))
      0: return OPC_ADD;
      1: return OPC_SUB;
      2: return OPC_MUL;
      default: return OPC_XOR;
    endcase
  endfunction

  // Sender pause: nothing new is offered until every owed status item has arrived.
  task automatic wait_idle();
    do @(negedge clk); while (pending_instrs.size() != 0 || owed_status.size() != 0);
  endtask

  // Builds random programs. Most are well formed (expressions, filling the stack,
  // draining it) with random values; the rest are loose stack mixes or random opcode bytes.
  task automatic random_programs(input int count);
    int planned;
    int kind;
    int n;
    logic [OP_W-1:0] opc;
    planned = 0;
    while (planned < count) begin
      kind = $urandom_range(0, 99);
      if (kind < 15) begin
        // Fill the stack, then push past full so the extra words are dropped.
        while (plan_depth < STACK_DEPTH_DEF) begin
          add_instr(OPC_PUSH, pick_operand());
          planned++;
        end
        n = $urandom_range(1, 2);
        repeat (n) add_instr(OPC_PUSH, pick_operand());
        n = $urandom_range(1, 3);
        repeat (n) add_instr(pick_binop(), pick_operand());
        planned += 6;
      end else if (kind < 55) begin
        // A small expression, printed half of the time.
        n = $urandom_range(2, 4);
        repeat (n) add_instr(OPC_PUSH, pick_operand());
        repeat (n - 1) add_instr(pick_binop(), pick_operand());
        if ($urandom_range(0, 1)) add_instr(OPC_PRINT, pick_operand());
        planned += 2 * n;
      end else if (kind < 70) begin
        // Empty the stack and then try once more on an empty stack.
        while (plan_depth > 0) begin
          add_instr($urandom_range(0, 1) ? OPC_PRINT : OPC_POP, pick_operand());
          planned++;
        end
        add_instr($urandom_range(0, 2) == 0 ? pick_binop() :
                  ($urandom_range(0, 1) ? OPC_PRINT : OPC_POP), pick_operand());
        planned++;
      end else if (kind < 85) begin
        // Loose mix of stack operations with no regard for depth.
        n = $urandom_range(3, 6);
        repeat (n) begin
          case ($urandom_range(0, 3))
            0, 1: add_instr(OPC_PUSH, pick_operand());
            2: add_instr($urandom_range(0, 1) ? OPC_PRINT : OPC_POP, pick_operand());
            default: add_instr(pick_binop(), pick_operand());
          endcase
        end
        planned += n;
      end else begin
        // Random opcode bytes; halt is kept for the end of the run.
        n = $urandom_range(1, 3);
        repeat (n) begin
          opc = OP_W'($urandom_range(0, 255));
          if (opc == OPC_HALT) opc = OPC_NOP;
          add_instr(opc, $urandom);
        end
        planned += n;
      end
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.op = OPC_NOP;
    in_ch.operand = '0;
    out_ch.ready = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed program: empty-stack cases, wraparound, operand order, every
    // arithmetic operation, print, and opcodes that must act as nop.
    add_instr(OPC_POP, '0);
    add_instr(OPC_PRINT, '0);
    add_instr(OPC_ADD, '1);
    add_instr(OPC_PUSH, '0);
    add_instr(OPC_SUB, '0);
    add_instr(OPC_PUSH, '1);
    add_instr(OPC_ADD, '0);
    add_instr(OPC_PUSH, 32'h1);
    add_instr(OPC_ADD, '0);
    add_instr(OPC_PUSH, 32'h3);
    add_instr(OPC_SUB, '0);
    add_instr(OPC_PUSH, '1);
    add_instr(OPC_MUL, '0);
    add_instr(OPC_PUSH, 32'h8000_0000);
    add_instr(OPC_XOR, '0);
    add_instr(OPC_PRINT, '0);
    add_instr(OPC_NOP, '1);
    add_instr(OPC_UNUSED_GAP, '1);
    add_instr(OPC_ALL_ONES, '1);
    add_instr(OPC_PUSH, 32'h0000_0048);
    add_instr(OPC_PRINT, '1);
    add_instr(OPC_POP, '1);
    wait_idle();

    // Random phases: no idling, then a slow sender, then a slow receiver, then both.
    random_programs(RANDOM_ITEMS);
    wait_idle();
    send_idle_pct = 68;
    random_programs(RANDOM_ITEMS);
    wait_idle();
    send_idle_pct = 0;
    recv_stall_pct = 68;
    random_programs(RANDOM_ITEMS);
    wait_idle();
    send_idle_pct = 8;
    recv_stall_pct = 8;
    random_programs(RANDOM_ITEMS);

    // Halt is sticky, so it comes last; everything after it must be ignored.
    add_instr(OPC_HALT, '0);
    add_instr(OPC_PUSH, $urandom);
    add_instr(OPC_PRINT, '0);
    add_instr(OPC_ADD, '0);
    add_instr(OPC_HALT, '1);
    add_instr(OPC_POP, '0);
    wait_idle();
    repeat (8) @(posedge clk);

    $display("Ran %0d instructions: %0d characters printed, %0d pushes dropped on a full",
             executed, chars_printed, pushes_dropped);
    $display("stack, peak depth %0d, halt reached: %0d.", peak_depth, halt_seen);
    if (fail_count == 0) begin
      $display("** stack_machine_executor: PASSED **");
    end else begin
      $display("** stack_machine_executor: FAILED **");
    end
    $finish;
  end

endmodule
